FILE: src/gait_phase_detector_macros.svh
// assertion macros used by the checker file
`ifndef GAIT_PHASE_DETECTOR_MACROS_SVH
`define GAIT_PHASE_DETECTOR_MACROS_SVH

// same-cycle implication, off while in reset
`define GPD_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define GPD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication that also covers reset cycles
`define GPD_ASSERT_ALWAYS_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: src/gpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_pkg
// shared constants and types of the gait phase detector
// ----------------------------------------------------------------------------
package gpd_pkg;

    localparam int TICK_W          = 32;
    localparam int SAMPLE_W        = 16;
    localparam int PERIOD_W        = 15;
    localparam int STEP_OUT_W      = 3;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int HISTORY_DEPTH_DEF = 3;
    localparam int READY_STEPS_DEF   = 5;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORCE_THR = 8'd0,
        REG_SLOPE_THR = 8'd1
    } t_reg_idx;

    typedef struct packed {
        logic [TICK_W-1:0]          tick_count;
        logic signed [SAMPLE_W-1:0] heel_force;
        logic signed [SAMPLE_W-1:0] heel_force_slope;
    } t_sample;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] force_thr;
        logic signed [SAMPLE_W-1:0] slope_thr;
    } t_thresholds;

    typedef struct packed {
        logic                push;
        logic [PERIOD_W-1:0] period;
    } t_hist_push;

    typedef struct packed {
        logic                  gait_phase;
        logic [TICK_W-1:0]     strike_stamp;
        logic [PERIOD_W-1:0]   mean_period;
        logic [STEP_OUT_W-1:0] step_count;
        logic                  detect_ready;
    } t_result;

endpackage

FILE: src/gpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_if
// sample, result and register write channels of the gait phase detector
// ----------------------------------------------------------------------------
interface gpd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [gpd_pkg::TICK_W-1:0]           tick_count;
    logic signed [gpd_pkg::SAMPLE_W-1:0]  heel_force;
    logic signed [gpd_pkg::SAMPLE_W-1:0]  heel_force_slope;

    modport source (output valid, tick_count, heel_force, heel_force_slope, input ready);
    modport sink   (input valid, tick_count, heel_force, heel_force_slope, output ready);
endinterface

interface gpd_out_if;
    logic                             valid;
    logic                             ready;
    logic                             gait_phase;
    logic [gpd_pkg::TICK_W-1:0]       strike_stamp;
    logic [gpd_pkg::PERIOD_W-1:0]     mean_period;
    logic [gpd_pkg::STEP_OUT_W-1:0]   step_count;
    logic                             detect_ready;

    modport source (output valid, gait_phase, strike_stamp, mean_period, step_count,
                    detect_ready, input ready);
    modport sink   (input valid, gait_phase, strike_stamp, mean_period, step_count,
                    detect_ready, output ready);
endinterface

interface gpd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gpd_pkg::CFG_IDX_W-1:0]     index;
    logic [gpd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/gait_phase_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gait_phase_detector
// heel strike gait phase detector with stride period averaging
// ----------------------------------------------------------------------------
// Usage:
//   i_in   sample requests (tick count, heel force, force slope), valid/ready
//   o_out  one result request per sample: phase, strike stamp, mean period,
//          step count and ready flag, valid/ready
//   i_cfg  register writes: index 0 force threshold, 1 slope threshold;
//          always ready, other indexes are ignored
// Path from sample acceptance to result valid: the input register feeds the
// phase update, which loads the result register when the output advances.
// Throughput is one sample per cycle while the receiver takes results, set
// by the state update, computed combinationally between the registers
// (compare, period subtract, running sum and reciprocal multiply).
// Reset (synchronous, active low) returns to swing, clears the strike stamp,
// period history, step count and ready flag, and sets both thresholds to 0.
// When the receiver stalls, the result register holds and one more sample
// can wait in the input register; i_in.ready drops only when both are full.
// ----------------------------------------------------------------------------
module gait_phase_detector #(
    parameter int HISTORY_DEPTH = gpd_pkg::HISTORY_DEPTH_DEF,
    parameter int READY_STEPS   = gpd_pkg::READY_STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gpd_in_if.sink     i_in,
    gpd_out_if.source  o_out,
    gpd_cfg_if.sink    i_cfg
);

    logic                 r_in_valid;
    gpd_pkg::t_sample     r_in;
    logic                 r_out_valid;
    gpd_pkg::t_result     r_out;
    gpd_pkg::t_thresholds r_thr;

    logic                 advance;
    logic                 step;
    gpd_pkg::t_result     result;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign step       = r_in_valid && advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gpd_pkg::REG_FORCE_THR: r_thr.force_thr <= $signed(i_cfg.data);
                gpd_pkg::REG_SLOPE_THR: r_thr.slope_thr <= $signed(i_cfg.data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.tick_count       <= i_in.tick_count;
            r_in.heel_force       <= i_in.heel_force;
            r_in.heel_force_slope <= i_in.heel_force_slope;
        end
    end

    gpd_tracker #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .READY_STEPS   (READY_STEPS)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sample (r_in),
        .i_thr    (r_thr),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.gait_phase   = r_out.gait_phase;
    assign o_out.strike_stamp = r_out.strike_stamp;
    assign o_out.mean_period  = r_out.mean_period;
    assign o_out.step_count   = r_out.step_count;
    assign o_out.detect_ready = r_out.detect_ready;

endmodule

FILE: src/gpd_history.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_history
// stride period history with running sum and rounded mean
// ----------------------------------------------------------------------------
module gpd_history #(
    parameter int DEPTH = gpd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gpd_pkg::t_hist_push          i_push,
    output logic [gpd_pkg::PERIOD_W-1:0] o_mean
);

    localparam int PW    = gpd_pkg::PERIOD_W;
    localparam int LG    = $clog2(DEPTH);
    localparam int SUM_W = PW + LG;
    localparam int X_W   = SUM_W + 1;
    localparam int SH    = X_W + LG;
    localparam int MUL_W = X_W + 1;
    localparam int PROD_W = X_W + MUL_W;
    // ceil(2^SH / DEPTH): exact quotient for every x below 2^X_W
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    logic [PW-1:0]     r_hist [DEPTH];
    logic [SUM_W-1:0]  r_sum;
    logic [PW-1:0]     r_mean;

    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  n_sum;
    logic [X_W-1:0]    biased;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-SH-1:0] quot;
    logic [PW-1:0]     n_mean;

    // drop the oldest entry, add the new one
    assign sum_wide = {1'b0, r_sum} + (SUM_W+1)'(i_push.period)
                    - (SUM_W+1)'(r_hist[DEPTH-1]);
    assign n_sum    = sum_wide[SUM_W-1:0];
    assign biased   = X_W'(n_sum) + X_W'(DEPTH / 2);
    assign prod     = PROD_W'(biased) * PROD_W'(RECIP);
    assign quot     = prod[PROD_W-1:SH];
    assign n_mean   = quot[PW-1:0];

    assign o_mean = i_push.push ? n_mean : r_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_sum  <= '0;
            r_mean <= '0;
        end else if (i_push.push) begin
            for (int i = DEPTH - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= i_push.period;
            r_sum     <= n_sum;
            r_mean    <= n_mean;
        end
    end

endmodule

FILE: src/gpd_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_tracker
// swing/stance phase tracking, strike stamp and step counting
// ----------------------------------------------------------------------------
module gpd_tracker #(
    parameter int HISTORY_DEPTH = gpd_pkg::HISTORY_DEPTH_DEF,
    parameter int READY_STEPS   = gpd_pkg::READY_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  gpd_pkg::t_sample     i_sample,
    input  gpd_pkg::t_thresholds i_thr,
    output gpd_pkg::t_result     o_result
);

    localparam int STEP_W = $clog2(READY_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_SAT = STEP_W'(READY_STEPS);

    logic                         r_phase;
    logic [gpd_pkg::TICK_W-1:0]   r_stamp;
    logic [STEP_W-1:0]            r_steps;
    logic                         r_ready;

    logic                         n_phase;
    logic [gpd_pkg::TICK_W-1:0]   n_stamp;
    logic [STEP_W-1:0]            n_steps;
    logic                         n_ready;

    logic                         strike;
    logic                         lift;
    logic signed [gpd_pkg::SAMPLE_W:0] slope_ext;
    logic signed [gpd_pkg::SAMPLE_W:0] neg_slope_thr;
    logic [gpd_pkg::TICK_W-1:0]   diff;
    gpd_pkg::t_hist_push          push;
    logic [gpd_pkg::PERIOD_W-1:0] mean;
    logic [31:0]                  steps_wide;

    assign strike = !r_phase
                  && (i_sample.heel_force_slope > i_thr.slope_thr)
                  && (i_sample.heel_force < i_thr.force_thr);

    // threshold negated at one extra bit so the most negative value works
    assign neg_slope_thr = -$signed({i_thr.slope_thr[gpd_pkg::SAMPLE_W-1], i_thr.slope_thr});
    assign slope_ext     = $signed({i_sample.heel_force_slope[gpd_pkg::SAMPLE_W-1],
                                    i_sample.heel_force_slope});
    assign lift = r_phase
                && (slope_ext < neg_slope_thr)
                && (i_sample.heel_force > i_thr.force_thr);

    assign diff        = i_sample.tick_count - r_stamp;
    assign push.push   = i_step && strike;
    assign push.period = (|diff[gpd_pkg::TICK_W-1:gpd_pkg::PERIOD_W]) ? gpd_pkg::PERIOD_MAX
                                                                     : diff[gpd_pkg::PERIOD_W-1:0];

    gpd_history #(
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_mean  (mean)
    );

    always_comb begin
        n_phase = r_phase;
        n_stamp = r_stamp;
        n_steps = r_steps;
        n_ready = r_ready;
        if (strike) begin
            n_phase = 1'b1;
            n_stamp = i_sample.tick_count;
            if (r_steps < STEP_SAT) begin
                n_steps = r_steps + STEP_W'(1);
            end
            if (n_steps == STEP_SAT) begin
                n_ready = 1'b1;
            end
        end else if (lift) begin
            n_phase = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_stamp <= '0;
            r_steps <= '0;
            r_ready <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_stamp <= n_stamp;
            r_steps <= n_steps;
            r_ready <= n_ready;
        end
    end

    assign steps_wide = 32'(n_steps);

    assign o_result.gait_phase   = n_phase;
    assign o_result.strike_stamp = n_stamp;
    assign o_result.mean_period  = mean;
    assign o_result.step_count   = steps_wide[gpd_pkg::STEP_OUT_W-1:0];
    assign o_result.detect_ready = n_ready;

endmodule

FILE: src/gpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_checker
// port-level checks of the gait phase detector, bound to the top level
// ----------------------------------------------------------------------------
`include "gait_phase_detector_macros.svh"

module gpd_checker #(
    parameter int READY_STEPS = gpd_pkg::READY_STEPS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic                             i_gait_phase,
    input logic [gpd_pkg::TICK_W-1:0]       i_strike_stamp,
    input logic [gpd_pkg::PERIOD_W-1:0]     i_mean_period,
    input logic [gpd_pkg::STEP_OUT_W-1:0]   i_step_count,
    input logic                             i_detect_ready
);

    localparam logic [gpd_pkg::STEP_OUT_W-1:0] READY_CODE =
        gpd_pkg::STEP_OUT_W'(READY_STEPS);

    logic r_ready_seen;

    // ready flag is sticky once a result has shown it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_detect_ready) begin
            r_ready_seen <= 1'b1;
        end
    end

    `GPD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable({i_gait_phase, i_strike_stamp, i_mean_period, i_step_count, i_detect_ready}), "stalled result changed")
    `GPD_ASSERT_NOW(a_ready_count, i_out_valid && i_detect_ready, i_step_count == READY_CODE, "ready flag without full step count")
    `GPD_ASSERT_NOW(a_ready_sticky, r_ready_seen && i_out_valid, i_detect_ready, "ready flag dropped")
    `GPD_ASSERT_NOW(a_in_free, !i_out_valid, i_in_ready, "input stalled with empty output")
    `GPD_ASSERT_ALWAYS_NEXT(a_reset_empty, !i_rst_n, !i_out_valid, "result valid right after reset")

endmodule

bind gait_phase_detector gpd_checker #(
    .READY_STEPS (READY_STEPS)
) u_gpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_gait_phase   (o_out.gait_phase),
    .i_strike_stamp (o_out.strike_stamp),
    .i_mean_period  (o_out.mean_period),
    .i_step_count   (o_out.step_count),
    .i_detect_ready (o_out.detect_ready)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the gait phase detector: a directed table, then
// random strike and lift sequences under several threshold settings, with
// random idling on both sides and one long output stall, all results checked
// in order against directed table values or an in-bench phase tracker
// ----------------------------------------------------------------------------
module tb;
    import gpd_pkg::*;

    localparam int HIST_D         = HISTORY_DEPTH_DEF;
    localparam int N_PHASES       = 7;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int LATENCY_PAUSE  = 8;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
    localparam logic [TICK_W-1:0]          TICK_TOP = '1;
    localparam logic [CFG_IDX_W-1:0]       REG_IDX_UNUSED = REG_SLOPE_THR + 1;
    localparam logic [CFG_IDX_W-1:0]       REG_IDX_TOP = '1;

    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_sample               smp;
        logic                  typed;
        t_result               want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    gpd_in_if  in_if();
    gpd_out_if out_if();
    gpd_cfg_if cfg_if();

    gait_phase_detector i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // tracker state
    logic                         stance_q;
    logic [TICK_W-1:0]            stamp_q;
    logic [PERIOD_W-1:0]          mean_q;
    logic [PERIOD_W-1:0]          hist_q [HIST_D];
    logic [STEP_OUT_W-1:0]        steps_q;
    logic                         rdy_q;
    logic signed [SAMPLE_W-1:0]   force_thr_q;
    logic signed [SAMPLE_W-1:0]   slope_thr_q;

    t_result           gait_results_due [$];
    logic [TICK_W-1:0] tick_now;
    int                sent_n;
    int                got_n;
    int                n_fail;
    int                idle_n;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        stance_q    = 1'b0;
        stamp_q     = '0;
        mean_q      = '0;
        for (int k = 0; k < HIST_D; k++) hist_q[k] = '0;
        steps_q     = '0;
        rdy_q       = 1'b0;
        force_thr_q = '0;
        slope_thr_q = '0;
        sent_n      = 0;
        got_n       = 0;
        n_fail      = 0;
        idle_n      = 0;
    end

    function automatic t_result next_gait_result(t_sample s);
        logic [TICK_W-1:0] diff;
        logic [31:0]       sum;
        t_result           r;
        if (!stance_q) begin
            if (s.heel_force_slope > slope_thr_q && s.heel_force < force_thr_q) begin
                diff = s.tick_count - stamp_q;
                if (diff > TICK_W'(PERIOD_MAX)) diff = TICK_W'(PERIOD_MAX);
                for (int k = HIST_D - 1; k > 0; k--) hist_q[k] = hist_q[k-1];
                hist_q[0] = PERIOD_W'(diff);
                sum = 0;
                for (int k = 0; k < HIST_D; k++) sum += 32'(hist_q[k]);
                mean_q   = PERIOD_W'((sum + HIST_D / 2) / HIST_D);
                stamp_q  = s.tick_count;
                stance_q = 1'b1;
                if (steps_q < READY_STEPS_DEF) steps_q++;
                if (steps_q == READY_STEPS_DEF) rdy_q = 1'b1;
            end
        end else begin
            // negated slope threshold needs 17 bits
            if (int'(s.heel_force_slope) < -int'(slope_thr_q) && s.heel_force > force_thr_q)
                stance_q = 1'b0;
        end
        r.gait_phase   = stance_q;
        r.strike_stamp = stamp_q;
        r.mean_period  = mean_q;
        r.step_count   = steps_q;
        r.detect_ready = rdy_q;
        return r;
    endfunction

    function automatic t_result res(logic ph, logic [TICK_W-1:0] stamp, int mean, int steps,
                                    logic rdy);
        t_result r;
        r.gait_phase   = ph;
        r.strike_stamp = stamp;
        r.mean_period  = PERIOD_W'(mean);
        r.step_count   = STEP_OUT_W'(steps);
        r.detect_ready = rdy;
        return r;
    endfunction

    function automatic t_dir_row row_in(logic [TICK_W-1:0] tick, int frc, int slp);
        t_dir_row r;
        r = '0;
        r.smp.tick_count       = tick;
        r.smp.heel_force       = SAMPLE_W'(frc);
        r.smp.heel_force_slope = SAMPLE_W'(slp);
        return r;
    endfunction

    function automatic t_dir_row row_chk(logic [TICK_W-1:0] tick, int frc, int slp, t_result w);
        t_dir_row r;
        r       = row_in(tick, frc, slp);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    function automatic t_dir_row row_wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r          = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = val;
        return r;
    endfunction

    // random value in [lo, hi], anything at all when the range is empty
    function automatic logic signed [SAMPLE_W-1:0] pick_between(int lo, int hi);
        if (hi < lo) return SAMPLE_W'($urandom);
        return SAMPLE_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic t_sample gen_sample();
        int      fthr;
        int      sthr;
        int      pick;
        int      jump;
        t_sample s;
        fthr = force_thr_q;
        sthr = slope_thr_q;
        pick = $urandom_range(0, 99);
        jump = $urandom_range(0, 9);
        if (jump == 0) tick_now = $urandom;
        else if (jump == 1) tick_now += $urandom_range(30000, 40000);
        else tick_now += $urandom_range(0, 3000);
        s.tick_count       = tick_now;
        s.heel_force       = SAMPLE_W'($urandom);
        s.heel_force_slope = SAMPLE_W'($urandom);
        if (!stance_q && pick < 70) begin
            s.heel_force       = pick_between(int'(S_MIN), fthr - 1);
            s.heel_force_slope = pick_between(sthr + 1, int'(S_MAX));
        end else if (stance_q && pick < 65) begin
            s.heel_force       = pick_between(fthr + 1, int'(S_MAX));
            s.heel_force_slope = pick_between(int'(S_MIN), -sthr - 1);
        end else if (pick < 75) begin
            s.heel_force = force_thr_q;
        end else if (pick < 80) begin
            s.heel_force_slope = stance_q ? SAMPLE_W'(-sthr) : slope_thr_q;
        end
        return s;
    endfunction

    task automatic send_sample(t_sample s, logic typed, t_result want);
        t_result pred;
        int      gap;
        pred = next_gait_result(s);
        gait_results_due.push_back(typed ? want : pred);
        gap = ((sent_n / 40) % 3 == 1) ? 0 : $urandom_range(0, 10);
        sent_n++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid            <= 1'b1;
        in_if.tick_count       <= s.tick_count;
        in_if.heel_force       <= s.heel_force;
        in_if.heel_force_slope <= s.heel_force_slope;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            REG_FORCE_THR: force_thr_q = val;
            REG_SLOPE_THR: slope_thr_q = val;
            default: ;
        endcase
    endtask

    // stop offering samples and let every pending result drain
    task automatic settle();
        in_if.valid <= 1'b0;
        while (gait_results_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY_PAUSE) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
    endtask

    initial begin : stimulus
        t_dir_row                   rows [$];
        logic                       cfg_open;
        logic signed [SAMPLE_W-1:0] f_thr;
        logic signed [SAMPLE_W-1:0] s_thr;
        i_rst_n                <= 1'b0;
        in_if.valid            <= 1'b0;
        in_if.tick_count       <= '0;
        in_if.heel_force       <= '0;
        in_if.heel_force_slope <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= REG_FORCE_THR;
        cfg_if.data            <= '0;
        cfg_open = 1'b0;
        tick_now = $urandom;

        // thresholds at reset value zero: equal values never trigger
        rows.push_back(row_chk(100, 0, 0, res(0, 0, 0, 0, 0)));
        rows.push_back(row_chk(100, 0, 1, res(0, 0, 0, 0, 0)));
        rows.push_back(row_chk(100, -1, 1, res(1, 100, 33, 1, 0)));
        rows.push_back(row_chk(200, -1, 1, res(1, 100, 33, 1, 0)));
        rows.push_back(row_chk(300, 0, -1, res(1, 100, 33, 1, 0)));
        rows.push_back(row_chk(300, 1, -1, res(0, 100, 33, 1, 0)));
        // huge period saturates
        rows.push_back(row_chk(TICK_TOP, S_MIN, S_MAX, res(1, TICK_TOP, 10956, 2, 0)));
        rows.push_back(row_chk(0, S_MAX, S_MIN, res(0, TICK_TOP, 10956, 2, 0)));
        // tick wraps around, then a zero period
        rows.push_back(row_in(16, -5, 5));
        rows.push_back(row_in(20, S_MAX, S_MIN));
        rows.push_back(row_in(16, -5, 5));
        rows.push_back(row_in(30, 7, -7));
        rows.push_back(row_in(40016, -9, 9));
        rows.push_back(row_in(40050, 7, -7));
        // step count holds at its ceiling
        rows.push_back(row_in(40100, -9, 9));
        rows.push_back(row_wr(REG_IDX_UNUSED, S_MAX));
        rows.push_back(row_wr(REG_FORCE_THR, S_MAX));
        rows.push_back(row_wr(REG_SLOPE_THR, S_MIN));
        // lift impossible: force can never exceed the top threshold
        rows.push_back(row_in(40200, S_MAX, S_MIN));
        rows.push_back(row_wr(REG_FORCE_THR, S_MIN));
        rows.push_back(row_wr(REG_SLOPE_THR, S_MAX));
        rows.push_back(row_in(40300, -32767, S_MIN));
        // strike impossible: slope can never exceed the top threshold
        rows.push_back(row_in(40400, S_MIN, S_MAX));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].is_write) begin
                if (!cfg_open) settle();
                write_cfg(rows[k].reg_idx, rows[k].reg_data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    cfg_if.valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_sample(rows[k].smp, rows[k].typed, rows[k].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    f_thr = SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
                    s_thr = SAMPLE_W'(int'($urandom_range(0, 600)) - 100);
                end
                1: begin f_thr = S_MAX; s_thr = S_MIN; end
                2: begin f_thr = '0;    s_thr = '0;    end
                3: begin f_thr = S_MIN; s_thr = S_MAX; end
                4: begin f_thr = S_MAX; s_thr = S_MAX; end
                5: begin f_thr = S_MIN; s_thr = S_MIN; end
                default: begin
                    f_thr = SAMPLE_W'($urandom);
                    s_thr = SAMPLE_W'($urandom);
                end
            endcase
            settle();
            if (ph % 2 == 1) write_cfg(REG_IDX_TOP, CFG_DATA_W'($urandom));
            write_cfg(REG_FORCE_THR, f_thr);
            write_cfg(REG_SLOPE_THR, s_thr);
            cfg_if.valid <= 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_sample(gen_sample(), 1'b0, '0);
        end

        settle();
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // result side: random idling, one long stall so the block backs up
    initial begin : result_sink
        int wait_n;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (got_n == HOLD_AT) wait_n = HOLD_CYCLES;
            else wait_n = ((got_n / 40) % 3 == 2) ? 0 : $urandom_range(0, 10);
            if (wait_n > 0) begin
                out_if.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            got_n++;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (gait_results_due.size() == 0) begin
                flag_mismatch("result request with nothing pending", 0, 1);
            end else begin
                want = gait_results_due.pop_front();
                if (out_if.gait_phase !== want.gait_phase)
                    flag_mismatch("gait_phase", want.gait_phase, out_if.gait_phase);
                if (out_if.strike_stamp !== want.strike_stamp)
                    flag_mismatch("strike_stamp", want.strike_stamp, out_if.strike_stamp);
                if (out_if.mean_period !== want.mean_period)
                    flag_mismatch("mean_period", want.mean_period, out_if.mean_period);
                if (out_if.step_count !== want.step_count)
                    flag_mismatch("step_count", want.step_count, out_if.step_count);
                if (out_if.detect_ready !== want.detect_ready)
                    flag_mismatch("detect_ready", want.detect_ready, out_if.detect_ready);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_n <= 0;
        else
            idle_n <= idle_n + 1;
    end

    initial begin : watchdog
        wait (idle_n >= WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
